[rtl/jsu_pkg.sv]
// Shared types and constants for the JSON string unescaper.
// Used by the front decoder, the entry queue, the back serialiser and the top level.
package jsu_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'd32;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_ESCAPE = 3'd1,
        PH_HEX0   = 3'd2,
        PH_HEX1   = 3'd3,
        PH_HEX2   = 3'd4,
        PH_HEX3   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BAD_HEX = 2'd1,
        ERR_SHORT_U = 2'd2
    } t_err;

    // One decoded input item: up to three data bytes, plus end-of-string info.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            last;
        t_err            err;
    } t_entry;

endpackage

[rtl/jsu_front.sv]
// Front decoder: accepts content bytes, tracks escape state and emits queue entries.
// Depends on jsu_pkg.
module jsu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_in_byte,
    input  logic             i_byte_present,
    input  logic             i_last_in,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output jsu_pkg::t_entry  o_entry
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [11:0]     r_accum, n_accum;
    jsu_pkg::t_err   r_err, n_err;

    logic            accept;
    logic            take;
    logic            hex_ok;
    logic [3:0]      hex_d;
    logic [15:0]     cp;
    logic [2:0][7:0] data;
    logic [1:0]      count;
    jsu_pkg::t_err   err_final;
    logic            in_hex;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign take    = i_byte_present && (r_err == jsu_pkg::ERR_NONE);
    assign cp      = {r_accum, hex_d};

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_d = i_in_byte[3:0];
        end else if ((i_in_byte >= 8'h61 && i_in_byte <= 8'h66) ||
                     (i_in_byte >= 8'h41 && i_in_byte <= 8'h46)) begin
            hex_d = i_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_err     = r_err;
        data      = '0;
        count     = 2'd0;
        err_final = jsu_pkg::ERR_NONE;
        in_hex    = 1'b0;
        if (take) begin
            case (r_phase)
                jsu_pkg::PH_ESCAPE: begin
                    n_phase = jsu_pkg::PH_NORMAL;
                    count   = 2'd1;
                    case (i_in_byte)
                        8'h62: data[0] = 8'd8;
                        8'h66: data[0] = 8'd12;
                        8'h6E: data[0] = 8'd10;
                        8'h72: data[0] = 8'd13;
                        8'h74: data[0] = 8'd9;
                        8'h76: data[0] = 8'd11;
                        8'h75: begin
                            count   = 2'd0;
                            n_phase = jsu_pkg::PH_HEX0;
                            n_accum = '0;
                        end
                        default: begin
                            data[0] = i_in_byte;
                            // drop an escaped NUL
                            if (i_in_byte == 8'd0) begin
                                count = 2'd0;
                            end
                        end
                    endcase
                end
                jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                    if (!hex_ok) begin
                        n_err   = jsu_pkg::ERR_BAD_HEX;
                        n_phase = jsu_pkg::PH_NORMAL;
                        n_accum = '0;
                    end else begin
                        n_accum = {r_accum[7:0], hex_d};
                        case (r_phase)
                            jsu_pkg::PH_HEX0: n_phase = jsu_pkg::PH_HEX1;
                            jsu_pkg::PH_HEX1: n_phase = jsu_pkg::PH_HEX2;
                            default:          n_phase = jsu_pkg::PH_HEX3;
                        endcase
                    end
                end
                jsu_pkg::PH_HEX3: begin
                    n_phase = jsu_pkg::PH_NORMAL;
                    n_accum = '0;
                    if (!hex_ok) begin
                        n_err = jsu_pkg::ERR_BAD_HEX;
                    end else if (cp < 16'h0080) begin
                        data[0] = cp[7:0];
                        count   = (cp == 16'd0) ? 2'd0 : 2'd1;
                    end else if (cp < 16'h0800) begin
                        data[0] = 8'hC0 | {3'b000, cp[10:6]};
                        data[1] = 8'h80 | {2'b00, cp[5:0]};
                        count   = 2'd2;
                    end else begin
                        data[0] = 8'hE0 | {4'h0, cp[15:12]};
                        data[1] = 8'h80 | {2'b00, cp[11:6]};
                        data[2] = 8'h80 | {2'b00, cp[5:0]};
                        count   = 2'd3;
                    end
                end
                default: begin
                    n_phase = jsu_pkg::PH_NORMAL;
                    data[0] = i_in_byte;
                    if (i_in_byte == jsu_pkg::CH_BSLASH) begin
                        n_phase = jsu_pkg::PH_ESCAPE;
                    end else if (i_in_byte >= jsu_pkg::CH_SPACE ||
                                 i_in_byte == jsu_pkg::CH_TAB) begin
                        count = 2'd1;
                    end
                end
            endcase
        end
        if (i_last_in) begin
            in_hex = (n_phase == jsu_pkg::PH_HEX0) || (n_phase == jsu_pkg::PH_HEX1) ||
                     (n_phase == jsu_pkg::PH_HEX2) || (n_phase == jsu_pkg::PH_HEX3);
            err_final = n_err;
            if (n_err == jsu_pkg::ERR_NONE && in_hex) begin
                err_final = jsu_pkg::ERR_SHORT_U;
            end
            // start the next string clean
            n_phase = jsu_pkg::PH_NORMAL;
            n_accum = '0;
            n_err   = jsu_pkg::ERR_NONE;
        end
    end

    assign o_push        = accept && ((count != 2'd0) || i_last_in);
    assign o_entry.data  = data;
    assign o_entry.count = count;
    assign o_entry.last  = i_last_in;
    assign o_entry.err   = err_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_NORMAL;
            r_accum <= '0;
            r_err   <= jsu_pkg::ERR_NONE;
        end else if (accept) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_err   <= n_err;
        end
    end

endmodule

[rtl/jsu_fifo.sv]
// Short queue of decoded entries between the front decoder and the back serialiser.
// Depends on jsu_pkg for the entry type and depth.
module jsu_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jsu_pkg::t_entry  i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output jsu_pkg::t_entry  o_head
);

    localparam int CW = jsu_pkg::FIFO_AW + 1;

    jsu_pkg::t_entry              r_mem [jsu_pkg::FIFO_DEPTH];
    logic [jsu_pkg::FIFO_AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         do_push, do_pop;

    assign o_full  = (r_cnt == CW'(jsu_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + jsu_pkg::FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + jsu_pkg::FIFO_AW'(1);
            end
        end
    end

endmodule

[rtl/jsu_back.sv]
// Back serialiser: walks each queued entry byte by byte into the output register.
// Depends on jsu_pkg for the entry type.
module jsu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  jsu_pkg::t_entry  i_head,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_present,
    output logic             o_last_out,
    output logic [1:0]       o_error_kind
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_present;
    logic       r_last;
    logic [1:0] r_err;
    logic [1:0] r_idx, n_idx;

    logic       load;
    logic       take;
    logic [1:0] final_idx;
    logic       at_end;

    assign load      = !r_valid || !i_stall;
    assign take      = load && !i_empty;
    // a bare end marker still takes one result slot
    assign final_idx = (i_head.count == 2'd0) ? 2'd0 : i_head.count - 2'd1;
    assign at_end    = (r_idx == final_idx);
    assign o_pop     = take && at_end;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = at_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_present <= (i_head.count != 2'd0);
            r_byte    <= (i_head.count != 2'd0) ? i_head.data[r_idx] : 8'd0;
            r_last    <= i_head.last && at_end;
            r_err     <= (i_head.last && at_end) ? i_head.err : jsu_pkg::ERR_NONE;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_out_present = r_present;
    assign o_last_out    = r_last;
    assign o_error_kind  = r_err;

endmodule

[rtl/json_string_unescaper_unit.sv]
// JSON string unescaper: one content byte in, zero to three unescaped bytes out.
// Usage:
//   Input channel (i_valid / o_stall) carries one content byte of a quoted string per
//   item, with i_byte_present low for an empty string and i_last_in on the final item.
//   Output channel (o_valid / i_stall) carries one byte per item; o_out_present low marks
//   a bare end marker, o_last_out flags the final result and o_error_kind holds the
//   string's error code on that result (zero elsewhere).
//   When the queue and the output register are empty, an accepted item is written into the
//   queue and then loaded into the output register, which raises o_valid.
//   Throughput is one input item per cycle while each yields at most one byte and i_stall
//   is low; a \u escape that encodes to two or three UTF-8 bytes is sent one byte at a time
//   through the single-byte output register. A four-entry queue absorbs the burst, and
//   o_stall rises only when the queue is full.
//   Reset (i_rst_n low, synchronous) empties the queue and output register and returns
//   the escape state to normal with no error held.
//   While i_stall is high the output item holds; the front keeps accepting until the
//   queue fills.
module json_string_unescaper_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_byte_present,
    input  logic       i_last_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_present,
    output logic       o_last_out,
    output logic [1:0] o_error_kind
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    jsu_pkg::t_entry entry;
    jsu_pkg::t_entry head;

    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_last_in      (i_last_in),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_entry        (entry)
    );

    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_out_present (o_out_present),
        .o_last_out    (o_last_out),
        .o_error_kind  (o_error_kind)
    );

endmodule

[dv/json_string_unescaper_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the JSON string unescaper: directed rows, then random strings.
// Depends on jsu_pkg and the rtl modules under json_string_unescaper_unit.
module json_string_unescaper_unit_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 480;
    localparam int IDLE_PCT     = 27;

    typedef struct packed {
        logic [7:0]    data;
        logic          present;
        logic          last;
        jsu_pkg::t_err err;
    } t_out_item;

    // One input item, with a typed-in result where the row gives one.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       present;
        logic       last;
        logic       typed;
        logic       has_out;
        t_out_item  out;
    } t_row;

    localparam t_out_item NO_OUT = '{8'h00, 1'b0, 1'b0, jsu_pkg::ERR_NONE};

    localparam t_row DIR_ROWS [28] = '{
        // empty string: bare end marker only
        '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE}},
        '{"A", 1'b1, 1'b0, 1'b1, 1'b1, '{"A", 1'b1, 1'b0, jsu_pkg::ERR_NONE}},
        '{8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, jsu_pkg::ERR_NONE}},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_OUT},
        '{jsu_pkg::CH_TAB, 1'b1, 1'b0, 1'b1, 1'b1,
          '{jsu_pkg::CH_TAB, 1'b1, 1'b0, jsu_pkg::ERR_NONE}},
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b1, 1'b0, NO_OUT},
        '{"n", 1'b1, 1'b0, 1'b1, 1'b1, '{8'h0A, 1'b1, 1'b0, jsu_pkg::ERR_NONE}},
        // escaped NUL is dropped
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b1, 1'b0, NO_OUT},
        '{8'h00, 1'b1, 1'b0, 1'b1, 1'b0, NO_OUT},
        // top of the range, three UTF-8 bytes
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"u", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"F", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"f", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"F", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"f", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        // code point zero yields nothing
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"u", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"0", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        // string ends inside the unicode escape
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"u", 1'b1, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jsu_pkg::ERR_SHORT_U}},
        // bad hex digit, then the next byte is suppressed
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"u", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"G", 1'b1, 1'b0, 1'b0, 1'b0, NO_OUT},
        '{"Z", 1'b1, 1'b1, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jsu_pkg::ERR_BAD_HEX}},
        // dangling backslash
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b1, 1'b1, 1'b1,
          '{8'h00, 1'b0, 1'b1, jsu_pkg::ERR_NONE}}
    };

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_byte_present = 1'b0;
    logic       i_last_in      = 1'b0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_present;
    logic       o_last_out;
    logic [1:0] o_error_kind;

    // Decoder state mirrored by the predictor
    jsu_pkg::t_phase esc_phase = jsu_pkg::PH_NORMAL;
    logic [15:0]     cp_accum  = '0;
    jsu_pkg::t_err   held_err  = jsu_pkg::ERR_NONE;

    t_out_item  step_out[$];
    t_out_item  unescaped_q[$];
    t_row       sent_rows_q[$];
    logic [7:0] str_q[$];

    bit calm = 1'b0;
    int n_fail = 0;
    int n_bytes = 0;
    int n_empty = 0;
    int n_results = 0;
    int n_ends = 0;
    int n_err_ends = 0;
    int n_random_bytes = 0;
    int cycle_cnt = 0;

    json_string_unescaper_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_byte_present (i_byte_present),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_out_present  (o_out_present),
        .o_last_out     (o_last_out),
        .o_error_kind   (o_error_kind)
    );

    always #4 i_clk = ~i_clk;

    function automatic int hex_digit_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic void push_data(input logic [7:0] b);
        step_out.insert(step_out.size(), '{b, 1'b1, 1'b0, jsu_pkg::ERR_NONE});
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        str_q.insert(str_q.size(), b);
    endfunction

    // Work out the output items for one input item and advance the decoder state.
    function automatic void unescape_item(input logic [7:0] b, input logic present,
                                          input logic last);
        int d;
        step_out.delete();
        if (present && held_err == jsu_pkg::ERR_NONE) begin
            if (esc_phase == jsu_pkg::PH_ESCAPE) begin
                esc_phase = jsu_pkg::PH_NORMAL;
                case (b)
                    "b": push_data(8'd8);
                    "f": push_data(8'd12);
                    "n": push_data(8'd10);
                    "r": push_data(8'd13);
                    "t": push_data(8'd9);
                    "v": push_data(8'd11);
                    "u": begin
                        esc_phase = jsu_pkg::PH_HEX0;
                        cp_accum  = '0;
                    end
                    default: if (b != 8'h00) push_data(b);
                endcase
            end else if (esc_phase >= jsu_pkg::PH_HEX0 && esc_phase <= jsu_pkg::PH_HEX3) begin
                d = hex_digit_value(b);
                if (d < 0) begin
                    held_err  = jsu_pkg::ERR_BAD_HEX;
                    esc_phase = jsu_pkg::PH_NORMAL;
                    cp_accum  = '0;
                end else begin
                    cp_accum = {cp_accum[11:0], 4'(d)};
                    if (esc_phase == jsu_pkg::PH_HEX3) begin
                        if (cp_accum < 16'h0080) begin
                            if (cp_accum != 16'h0000) push_data(cp_accum[7:0]);
                        end else if (cp_accum < 16'h0800) begin
                            push_data({3'b110, cp_accum[10:6]});
                            push_data({2'b10, cp_accum[5:0]});
                        end else begin
                            push_data({4'b1110, cp_accum[15:12]});
                            push_data({2'b10, cp_accum[11:6]});
                            push_data({2'b10, cp_accum[5:0]});
                        end
                        esc_phase = jsu_pkg::PH_NORMAL;
                        cp_accum  = '0;
                    end else begin
                        esc_phase = jsu_pkg::t_phase'(esc_phase + 3'd1);
                    end
                end
            end else begin
                esc_phase = jsu_pkg::PH_NORMAL;
                if (b == jsu_pkg::CH_BSLASH) esc_phase = jsu_pkg::PH_ESCAPE;
                else if (b >= jsu_pkg::CH_SPACE || b == jsu_pkg::CH_TAB) push_data(b);
            end
        end
        if (last) begin
            if (held_err == jsu_pkg::ERR_NONE && esc_phase >= jsu_pkg::PH_HEX0 &&
                esc_phase <= jsu_pkg::PH_HEX3)
                held_err = jsu_pkg::ERR_SHORT_U;
            if (step_out.size() == 0) step_out.insert(0, NO_OUT);
            step_out[step_out.size() - 1].last = 1'b1;
            step_out[step_out.size() - 1].err  = held_err;
            esc_phase = jsu_pkg::PH_NORMAL;
            cp_accum  = '0;
            held_err  = jsu_pkg::ERR_NONE;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    // Input and output handshakes are both seen here, so ordering within a step is fixed.
    always @(posedge i_clk) begin : check_blk
        t_row      row;
        t_out_item want;
        if (i_rst_n && i_valid && !o_stall) begin
            row = sent_rows_q.pop_front();
            unescape_item(i_in_byte, i_byte_present, i_last_in);
            if (i_byte_present) n_bytes++;
            else n_empty++;
            if (row.typed) begin
                if (row.has_out) unescaped_q.insert(unescaped_q.size(), row.out);
            end else begin
                foreach (step_out[k]) unescaped_q.insert(unescaped_q.size(), step_out[k]);
            end
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (unescaped_q.size() == 0) begin
                $error("output item 0x%0h with nothing expected", o_out_byte);
                n_fail++;
            end else begin
                want = unescaped_q.pop_front();
                check_field("out_byte", want.data, o_out_byte);
                check_field("out_present", want.present, o_out_present);
                check_field("last_out", want.last, o_last_out);
                check_field("error_kind", want.err, o_error_kind);
                n_results++;
                if (o_last_out) n_ends++;
                if (o_last_out && o_error_kind != jsu_pkg::ERR_NONE) n_err_ends++;
            end
        end
    end

    always @(posedge i_clk) i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timed out with %0d output items outstanding", unescaped_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Present one item and hold it until accepted.
    task automatic send_item(input t_row row);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        sent_rows_q.insert(sent_rows_q.size(), row);
        i_valid        <= 1'b1;
        i_in_byte      <= row.in_byte;
        i_byte_present <= row.present;
        i_last_in      <= row.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (unescaped_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return "0" + {4'h0, v};
        return ($urandom_range(1) ? "a" : "A") + {4'h0, v - 4'd10};
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (hex_digit_value(b) >= 0);
        return b;
    endfunction

    function automatic logic [15:0] pick_code_point();
        case ($urandom_range(4))
            0: return 16'($urandom_range(16'h007F));
            1: return 16'($urandom_range(16'h07FF, 16'h0080));
            2: return 16'($urandom_range(16'hFFFF, 16'h0800));
            3: return 16'($urandom_range(16'hDFFF, 16'hD800));
            default: begin
                // boundaries between the one, two and three byte forms
                case ($urandom_range(5))
                    0: return 16'h0000;
                    1: return 16'h007F;
                    2: return 16'h0080;
                    3: return 16'h07FF;
                    4: return 16'h0800;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] escape_char();
        case ($urandom_range(11))
            0: return "b";
            1: return "f";
            2: return "n";
            3: return "r";
            4: return "t";
            5: return "v";
            6: return "\"";
            7: return "/";
            8: return jsu_pkg::CH_BSLASH;
            9: return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void add_unicode(input logic [15:0] cp, input int digits);
        put_byte(jsu_pkg::CH_BSLASH);
        put_byte("u");
        for (int k = 0; k < digits; k++) put_byte(hex_char(cp[15 - 4 * k -: 4]));
    endfunction

    // Mostly well-formed content, with some noise and broken escapes mixed in.
    function automatic void build_string();
        int n_tok;
        int sel;
        n_tok = $urandom_range(6, 1);
        str_q.delete();
        for (int t = 0; t < n_tok; t++) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                put_byte(8'($urandom_range(126, 32)));
            end else if (sel < 48) begin
                put_byte(jsu_pkg::CH_BSLASH);
                put_byte(escape_char());
            end else if (sel < 78) begin
                add_unicode(pick_code_point(), 4);
            end else if (sel < 88) begin
                put_byte(8'($urandom_range(255)));
            end else if (sel < 94) begin
                add_unicode(pick_code_point(), $urandom_range(3));
                put_byte(non_hex_byte());
            end else begin
                put_byte(8'($urandom_range(31)));
            end
        end
        case ($urandom_range(19))
            0: add_unicode(pick_code_point(), $urandom_range(3));
            1: put_byte(jsu_pkg::CH_BSLASH);
            default: ;
        endcase
    endfunction

    task automatic send_string();
        t_row row;
        bit   end_on_byte;
        row = '0;
        if ($urandom_range(19) == 0) begin
            row.in_byte = 8'($urandom_range(255));
            row.last    = 1'b1;
            send_item(row);
            return;
        end
        build_string();
        end_on_byte = ($urandom_range(9) < 7);
        for (int k = 0; k < str_q.size(); k++) begin
            if ($urandom_range(24) == 0) begin
                row.in_byte = 8'($urandom_range(255));
                row.present = 1'b0;
                row.last    = 1'b0;
                send_item(row);
            end
            row.in_byte = str_q[k];
            row.present = 1'b1;
            row.last    = end_on_byte && (k == str_q.size() - 1);
            send_item(row);
            n_random_bytes++;
        end
        if (!end_on_byte) begin
            row.in_byte = 8'($urandom_range(255));
            row.present = 1'b0;
            row.last    = 1'b1;
            send_item(row);
        end
    endtask

    initial begin
        int s;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIR_ROWS[k]) send_item(DIR_ROWS[k]);
        drain();
        s = 0;
        while (n_random_bytes < RANDOM_BYTES) begin
            calm <= (s >= 20 && s < 28);
            send_string();
            if (s % 12 == 11) drain();
            s++;
        end
        drain();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d content bytes and %0d empty items over %0d strings;",
                 n_bytes, n_empty, n_ends);
        $display("%0d output items compared, %0d strings closed with an error code.",
                 n_results, n_err_ends);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
